// ===== hdl/lvm_pkg.sv =====
// Shared types, constants and register codes for the stereo level meter.
package lvm_pkg;

  localparam int SAMPLE_BITS_DEF       = 24;
  localparam int LEVEL_BITS_DEF        = 16;
  localparam int WINDOW_COUNT_BITS_DEF = 16;

  localparam int THR_BITS     = 23;
  localparam int COEF_BITS    = 16;
  localparam int HOLD_BITS    = 18;
  localparam int WIN_BITS     = 16;
  localparam int SUM_BITS     = 62;
  localparam int LOG_BITS     = 22;
  localparam int CFG_IDX_BITS = 3;
  localparam int CFG_DAT_BITS = 23;
  localparam int K_BITS       = 29;

  // log10(2)/3 in Q0.32
  localparam logic [K_BITS-1:0] LOG2_TO_LEVEL = 29'd430971329;

  localparam logic [CFG_IDX_BITS-1:0] REG_MODE    = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_WINDOW  = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_HOLD    = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_THRESH  = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_ATTACK  = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] REG_RELEASE = 3'd5;
  localparam logic [CFG_IDX_BITS-1:0] REG_RMS     = 3'd6;

  typedef struct packed {
    logic                 mode;
    logic [HOLD_BITS-1:0] hold;
    logic [THR_BITS-1:0]  thr;
    logic [COEF_BITS-1:0] attack;
    logic [COEF_BITS-1:0] rel_step;
    logic [COEF_BITS-1:0] rms;
  } lvm_cfg_t;

  typedef struct packed {
    logic load;
    logic mag;
    logic acc;
    logic calc_start;
    logic clear;
  } lvm_ctl_t;

  typedef enum logic [2:0] {
    T_IDLE, T_MAG, T_ACC, T_START, T_WAIT, T_FINISH
  } top_state_t;

  typedef enum logic [3:0] {
    C_IDLE, C_TSQ, C_NTT, C_CHK, C_LOGT, C_LOGN, C_LOGX,
    C_DIFF, C_DROP, C_TGT, C_SMUL, C_SMOOTH
  } lane_state_t;

  typedef enum logic [1:0] {
    LG_IDLE, LG_NORM, LG_SQ, LG_DONE
  } log_state_t;

endpackage

// ===== hdl/lvm_log.sv =====
// Iterative log2 unit: normalize, then one squaring per fraction bit.
module lvm_log import lvm_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [63:0]         x,
  output logic                done,
  output logic [LOG_BITS-1:0] value
);

  log_state_t  state, state_next;
  logic [63:0] xn;
  logic [5:0]  p;
  logic [31:0] y;
  logic [15:0] f;
  logic [3:0]  i;
  logic [63:0] sq;
  logic [32:0] t;

  assign sq = 64'(y) * 64'(y);
  assign t  = sq[63:31];

  always_comb begin
    state_next = state;
    case (state)
      LG_IDLE: if (start) state_next = (x == 64'd0) ? LG_DONE : LG_NORM;
      LG_NORM: if (xn[63]) state_next = LG_SQ;
      LG_SQ:   if (i == 4'd15) state_next = LG_DONE;
      LG_DONE: state_next = LG_IDLE;
      default: state_next = LG_IDLE;
    endcase
  end

  always_comb begin
    done  = (state == LG_DONE);
    value = {p, f};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= LG_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      LG_IDLE: begin
        if (start) begin
          xn <= x;
          p  <= (x == 64'd0) ? 6'd0 : 6'd63;
          f  <= 16'd0;
          i  <= 4'd0;
        end
      end
      LG_NORM: begin
        if (xn[63:56] == 8'd0) begin
          xn <= xn << 8;
          p  <= p - 6'd8;
        end else if (!xn[63]) begin
          xn <= xn << 1;
          p  <= p - 6'd1;
        end else begin
          y <= xn[63:32];
        end
      end
      LG_SQ: begin
        f <= {f[14:0], t[32]};
        y <= t[32] ? t[32:1] : t[31:0];
        i <= i + 4'd1;
      end
      default: ;
    endcase
  end

endmodule

// ===== hdl/lvm_lane.sv =====
// One channel lane: accumulators, clip hold, target level and smoothing.
module lvm_lane import lvm_pkg::*; #(
  parameter int SAMPLE_BITS       = SAMPLE_BITS_DEF,
  parameter int LEVEL_BITS        = LEVEL_BITS_DEF,
  parameter int WINDOW_COUNT_BITS = WINDOW_COUNT_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  lvm_ctl_t                     ctl,
  input  lvm_cfg_t                     cfg,
  input  logic [SAMPLE_BITS-1:0]       sample,
  input  logic [WINDOW_COUNT_BITS-1:0] n,
  output logic [LEVEL_BITS-1:0]        level,
  output logic                         lit,
  output logic                         idle
);

  localparam int MB    = SAMPLE_BITS - 1;
  localparam int SQB   = 2 * MB;
  localparam int CW    = (SAMPLE_BITS > THR_BITS) ? SAMPLE_BITS : THR_BITS;
  localparam int TTB   = 2 * THR_BITS;
  localparam int NTB   = WINDOW_COUNT_BITS + TTB;
  localparam int CMPW  = (NTB > SUM_BITS) ? NTB : SUM_BITS;
  localparam int MW    = 24;
  localparam int DROPB = MW + K_BITS;
  localparam int PB    = COEF_BITS + LEVEL_BITS;
  localparam int DW    = LOG_BITS + 3;

  lane_state_t state, state_next;

  logic [SAMPLE_BITS-1:0] smp;
  logic [SAMPLE_BITS-1:0] mag;
  logic [MB-1:0]          pk;
  logic [MB-1:0]          pk_r;
  logic [SQB-1:0]         sq_r;
  logic                   clip_r;
  logic [MB-1:0]          peak;
  logic [SUM_BITS-1:0]    sum;
  logic [SUM_BITS:0]      sum_add;
  logic [HOLD_BITS-1:0]   cnt, cnt_next;

  logic [TTB-1:0]        tt;
  logic [NTB-1:0]        ntt;
  logic [LOG_BITS-1:0]   lt, ln, lx;
  logic [MW-1:0]         m;
  logic [DROPB-1:0]      drop;
  logic [DROPB-1:0]      ds;
  logic [LEVEL_BITS-1:0] tgt;
  logic [PB-1:0]         prod;
  logic                  ge;
  logic [63:0]           x_val;
  logic                  x_zero, x_full;
  logic signed [DW-1:0]  d_pk, d_rms, d_sel;
  logic [LEVEL_BITS-1:0] coef_dif_pr, r, v;
  logic [PB-1:0]         rr;
  logic [COEF_BITS-1:0]  coef;

  logic                log_start, log_done;
  logic [63:0]         log_x;
  logic [LOG_BITS-1:0] log_val;

  lvm_log u_log (
    .clk   (clk),
    .rst   (rst),
    .start (log_start),
    .x     (log_x),
    .done  (log_done),
    .value (log_val)
  );

  assign mag = smp[SAMPLE_BITS-1] ? (~smp + SAMPLE_BITS'(1)) : smp;
  assign pk  = mag[SAMPLE_BITS-1] ? {MB{1'b1}} : mag[MB-1:0];
  assign sum_add = {1'b0, sum} + (SUM_BITS+1)'(sq_r);

  always_comb begin
    if (clip_r) cnt_next = cfg.hold;
    else if (cnt <= HOLD_BITS'(1)) cnt_next = '0;
    else cnt_next = cnt - HOLD_BITS'(1);
  end

  assign x_val  = cfg.mode ? 64'(sum) : 64'(peak);
  assign x_zero = (x_val == 64'd0);
  assign x_full = (cfg.thr == '0) ||
                  (cfg.mode ? (CMPW'(sum) >= CMPW'(ntt)) : (CW'(peak) >= CW'(cfg.thr)));

  assign d_pk  = DW'(lt) - DW'(lx);
  assign d_rms = (DW'(lt) <<< 1) + DW'(ln) - DW'(lx);
  assign d_sel = cfg.mode ? d_rms : d_pk;

  assign ds  = drop >> (48 - LEVEL_BITS);
  assign coef = cfg.mode ? cfg.rms : cfg.attack;
  assign coef_dif_pr = prod[PB-1:COEF_BITS];
  assign rr  = {cfg.rel_step, {LEVEL_BITS{1'b0}}} >> COEF_BITS;
  assign r   = rr[LEVEL_BITS-1:0];
  assign v   = (level > r) ? (level - r) : '0;

  always_comb begin
    state_next = state;
    case (state)
      C_IDLE:   if (ctl.calc_start) state_next = C_TSQ;
      C_TSQ:    state_next = C_NTT;
      C_NTT:    state_next = C_CHK;
      C_CHK:    state_next = (x_zero || x_full) ? C_SMUL : C_LOGT;
      C_LOGT:   if (log_done) state_next = cfg.mode ? C_LOGN : C_LOGX;
      C_LOGN:   if (log_done) state_next = C_LOGX;
      C_LOGX:   if (log_done) state_next = C_DIFF;
      C_DIFF:   state_next = C_DROP;
      C_DROP:   state_next = C_TGT;
      C_TGT:    state_next = C_SMUL;
      C_SMUL:   state_next = C_SMOOTH;
      C_SMOOTH: state_next = C_IDLE;
      default:  state_next = C_IDLE;
    endcase
  end

  always_comb begin
    log_start = 1'b0;
    log_x     = 64'd0;
    case (state)
      C_LOGT: begin
        log_start = 1'b1;
        log_x     = 64'(cfg.thr);
      end
      C_LOGN: begin
        log_start = 1'b1;
        log_x     = 64'(n);
      end
      C_LOGX: begin
        log_start = 1'b1;
        log_x     = x_val;
      end
      default: ;
    endcase
    idle = (state == C_IDLE);
  end

  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      state <= C_IDLE;
      peak  <= '0;
      sum   <= '0;
      cnt   <= '0;
      lit   <= 1'b0;
      level <= '0;
    end else begin
      state <= state_next;
      if (ctl.acc) begin
        if (pk_r > peak) peak <= pk_r;
        sum <= sum_add[SUM_BITS] ? {SUM_BITS{1'b1}} : sum_add[SUM_BITS-1:0];
        cnt <= cnt_next;
        lit <= clip_r || (cnt_next != '0);
      end
      if (state == C_SMOOTH) begin
        peak <= '0;
        sum  <= '0;
        if (ge) level <= level + coef_dif_pr;
        else if (cfg.mode) level <= level - coef_dif_pr;
        else level <= (v > tgt) ? v : tgt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) smp <= sample;
    if (ctl.mag) begin
      pk_r   <= pk;
      sq_r   <= SQB'(pk) * SQB'(pk);
      clip_r <= CW'(mag) > CW'(cfg.thr);
    end
    case (state)
      C_TSQ:  tt  <= TTB'(cfg.thr) * TTB'(cfg.thr);
      C_NTT:  ntt <= NTB'(n) * NTB'(tt);
      C_CHK:  tgt <= x_zero ? '0 : {LEVEL_BITS{1'b1}};
      C_LOGT: if (log_done) lt <= log_val;
      C_LOGN: if (log_done) ln <= log_val;
      C_LOGX: if (log_done) lx <= log_val;
      C_DIFF: begin
        if (d_sel <= 0) m <= '0;
        else if (cfg.mode) m <= MW'(d_sel[DW-1:1]);
        else m <= MW'(d_sel);
      end
      C_DROP: drop <= DROPB'(m) * DROPB'(LOG2_TO_LEVEL);
      C_TGT: begin
        if (ds[DROPB-1:LEVEL_BITS] != '0) tgt <= '0;
        else if (ds[LEVEL_BITS-1:0] == '0) tgt <= {LEVEL_BITS{1'b1}};
        else tgt <= '0 - ds[LEVEL_BITS-1:0];
      end
      C_SMUL: begin
        ge <= (tgt >= level);
      end
      default: ;
    endcase
    if (state == C_SMUL) begin
      prod <= PB'(coef) * PB'((tgt >= level) ? (tgt - level) : (level - tgt));
    end
  end

endmodule

// ===== hdl/stereo_level_meter_unit.sv =====
// Top level: config registers, frame sequencer, two lanes and output merge.
// A frame is loaded and passes the magnitude, accumulate and finish steps;
// a frame that closes a window adds the lane calculation before finish:
// two log2 runs in peak mode or three in RMS mode, unless the window value
// is zero or reaches the threshold. The next frame is taken once the result
// is in the output register, where it may wait while that frame is in work.
// Reset (sync, rst high) loads register defaults and zeroes FSMs and levels.
module stereo_level_meter_unit import lvm_pkg::*; #(
  parameter int SAMPLE_BITS       = SAMPLE_BITS_DEF,
  parameter int LEVEL_BITS        = LEVEL_BITS_DEF,
  parameter int WINDOW_COUNT_BITS = WINDOW_COUNT_BITS_DEF,
  localparam int IDW = ((2 * SAMPLE_BITS + 7) / 8) * 8,
  localparam int ODW = ((3 * LEVEL_BITS + 4 + 7) / 8) * 8
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    s_tvalid,
  output logic                    s_tready,
  // sample_left, sample_right, zero pad
  input  logic [IDW-1:0]          s_tdata,
  output logic                    m_tvalid,
  input  logic                    m_tready,
  // level_left, level_right, level_mean, level_updated, clip_left,
  // clip_right, clip_any, zero pad
  output logic [ODW-1:0]          m_tdata,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [CFG_DAT_BITS-1:0] cfg_data
);

  localparam int WW = (WIN_BITS > WINDOW_COUNT_BITS) ? WIN_BITS : WINDOW_COUNT_BITS;
  localparam logic [WW-1:0] COUNT_MAX = WW'((64'd1 << WINDOW_COUNT_BITS) - 64'd1);
  localparam int OPB = ODW - (3 * LEVEL_BITS + 4);

  top_state_t state, state_next;
  lvm_cfg_t   cfg;
  logic [WIN_BITS-1:0]          window_frames;
  logic [WINDOW_COUNT_BITS-1:0] fc, n_r;
  logic [WINDOW_COUNT_BITS-1:0] n_inc;
  logic [WW-1:0]                win;
  logic                         close_r;
  logic                         cfg_we;
  logic                         load_out;
  lvm_ctl_t                     ctl;

  logic [LEVEL_BITS-1:0] lvl_l, lvl_r;
  logic                  lit_l, lit_r, idle_l, idle_r;
  logic [LEVEL_BITS:0]   lvl_sum;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mode      <= 1'b0;
      window_frames <= 16'd1600;
      cfg.hold      <= 18'd24000;
      cfg.thr       <= 23'd1048576;
      cfg.attack    <= 16'd65450;
      cfg.rel_step  <= 16'd1092;
      cfg.rms       <= 16'd26247;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MODE:    cfg.mode      <= cfg_data[0];
        REG_WINDOW:  window_frames <= cfg_data[WIN_BITS-1:0];
        REG_HOLD:    cfg.hold      <= cfg_data[HOLD_BITS-1:0];
        REG_THRESH:  cfg.thr       <= cfg_data[THR_BITS-1:0];
        REG_ATTACK:  cfg.attack    <= cfg_data[COEF_BITS-1:0];
        REG_RELEASE: cfg.rel_step  <= cfg_data[COEF_BITS-1:0];
        REG_RMS:     cfg.rms       <= cfg_data[COEF_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    win = (window_frames == '0) ? WW'(1) : WW'(window_frames);
    if (win > COUNT_MAX) win = COUNT_MAX;
  end

  assign n_inc = fc + WINDOW_COUNT_BITS'(1);

  always_comb begin
    state_next = state;
    case (state)
      T_IDLE:   if (s_tvalid) state_next = T_MAG;
      T_MAG:    state_next = T_ACC;
      T_ACC:    state_next = close_r ? T_START : T_FINISH;
      T_START:  state_next = T_WAIT;
      T_WAIT:   if (idle_l && idle_r) state_next = T_FINISH;
      T_FINISH: if (!m_tvalid || m_tready) state_next = T_IDLE;
      default:  state_next = T_IDLE;
    endcase
  end

  always_comb begin
    s_tready       = (state == T_IDLE);
    ctl.load       = (state == T_IDLE) && s_tvalid;
    ctl.mag        = (state == T_MAG);
    ctl.acc        = (state == T_ACC);
    ctl.calc_start = (state == T_START);
    ctl.clear      = cfg_we && (cfg_index == REG_MODE);
    load_out       = (state == T_FINISH) && (!m_tvalid || m_tready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= T_IDLE;
      fc      <= '0;
      n_r     <= '0;
      close_r <= 1'b0;
    end else begin
      state <= state_next;
      if (ctl.clear) begin
        fc <= '0;
      end else if (state == T_MAG) begin
        n_r     <= n_inc;
        close_r <= WW'(n_inc) >= win;
      end else if (state == T_ACC) begin
        fc <= close_r ? '0 : n_r;
      end
    end
  end

  lvm_lane #(
    .SAMPLE_BITS       (SAMPLE_BITS),
    .LEVEL_BITS        (LEVEL_BITS),
    .WINDOW_COUNT_BITS (WINDOW_COUNT_BITS)
  ) u_lane_l (
    .clk    (clk),
    .rst    (rst),
    .ctl    (ctl),
    .cfg    (cfg),
    .sample (s_tdata[SAMPLE_BITS-1:0]),
    .n      (n_r),
    .level  (lvl_l),
    .lit    (lit_l),
    .idle   (idle_l)
  );

  lvm_lane #(
    .SAMPLE_BITS       (SAMPLE_BITS),
    .LEVEL_BITS        (LEVEL_BITS),
    .WINDOW_COUNT_BITS (WINDOW_COUNT_BITS)
  ) u_lane_r (
    .clk    (clk),
    .rst    (rst),
    .ctl    (ctl),
    .cfg    (cfg),
    .sample (s_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]),
    .n      (n_r),
    .level  (lvl_r),
    .lit    (lit_r),
    .idle   (idle_r)
  );

  // merge stage
  assign lvl_sum = {1'b0, lvl_l} + {1'b0, lvl_r};

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      m_tdata <= {{OPB{1'b0}}, (lit_l | lit_r), lit_r, lit_l, close_r,
                  lvl_sum[LEVEL_BITS:1], lvl_r, lvl_l};
    end
  end

`ifndef NO_ASSERTIONS
  a_one_frame: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("frame taken while another is in work");

  a_lanes_idle: assert property (@(posedge clk) disable iff (rst)
    (state == T_IDLE) |-> (idle_l && idle_r))
    else $error("lane busy while sequencer idle");

  a_out_from_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state == T_FINISH))
    else $error("result beat without finish step");
`endif

endmodule
